[src/assert_macros.svh]
// Assertion macros shared by the depacketizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked at every rising edge of clk, suspended while rst_n is low.
`define ASSERT_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_CHK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[src/vp8d_pkg.sv]
// Types, constants and helpers shared by the VP8 RTP depacketizer.
`timescale 1ns / 1ps
`default_nettype none
package vp8d_pkg;

  localparam int CFG_W = 24;
  localparam logic [CFG_W-1:0] MAX_FRAME_RESET = 24'd524288;
  localparam int LEN_BITS_DEF = 24;
  localparam int OUT_DEPTH = 4;

  // Bit positions inside the descriptor flag byte.
  localparam int FL_N_BIT = 0;
  localparam int FL_S_BIT = 1;
  localparam int FL_L_BIT = 5;
  localparam int FL_T_BIT = 6;
  localparam int FL_K_BIT = 7;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_EXT     = 3'd1,
    PH_PIC     = 3'd2,
    PH_PIC2    = 3'd3,
    PH_TL0     = 3'd4,
    PH_TK      = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_JUDGE   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    KIND_BYTE      = 3'd0,
    KIND_COMPLETE  = 3'd1,
    KIND_ABORT     = 3'd2,
    KIND_TRUNCATED = 3'd3,
    KIND_TOO_LARGE = 3'd4
  } kind_t;

  typedef struct packed {
    logic [14:0] picture_id;
    logic [7:0]  tl0_index;
    logic [1:0]  temporal_id;
    logic        layer_sync;
    logic [4:0]  key_index;
  } hdr_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  frame_byte;
    logic        frame_first;
    logic        keyframe;
    logic        non_reference;
    logic [2:0]  partition_id;
    logic [14:0] picture_id;
    logic [7:0]  tl0_index;
    logic [1:0]  temporal_id;
    logic        layer_sync;
    logic [4:0]  key_index;
  } result_t;

  // Up to two results leave the parser for one item.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t d0;
    result_t d1;
  } res_push_t;

  function automatic result_t mk_res(kind_t k, logic [7:0] byte_v, logic first,
                                     logic key, logic [7:0] fl, hdr_t h);
    result_t r;
    r.kind          = k;
    r.frame_byte    = byte_v;
    r.frame_first   = first;
    r.keyframe      = key;
    r.non_reference = fl[FL_N_BIT];
    r.partition_id  = fl[4:2];
    r.picture_id    = h.picture_id;
    r.tl0_index     = h.tl0_index;
    r.temporal_id   = h.temporal_id;
    r.layer_sync    = h.layer_sync;
    r.key_index     = h.key_index;
    return r;
  endfunction

endpackage
`default_nettype wire

[src/vp8d_parser.sv]
// Input register, descriptor parser and frame reassembly state.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vp8d_parser import vp8d_pkg::*; #(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_first,
  input  wire logic             in_last,
  input  wire logic             in_marker,
  input  wire logic [15:0]      in_seq,
  input  wire logic [CFG_W-1:0] max_frame_bytes,
  input  wire logic             room,
  output res_push_t             push
);

  localparam int CMP_W = (LEN_BITS > CFG_W) ? LEN_BITS : CFG_W;

  logic                a_v_r;
  logic [7:0]          a_byte_r;
  logic                a_first_r, a_last_r, a_mark_r;
  logic [15:0]         a_seq_r;

  phase_t              ph_r, ph_nxt;
  logic [7:0]          fl_r, fl_nxt;
  hdr_t                hdr_r, hdr_nxt;
  logic                fo_r, fo_nxt;
  logic                pa_r, pa_nxt;
  logic                fk_r, fk_nxt;
  logic                fp_r, fp_nxt;
  logic [15:0]         lseq_r, lseq_nxt;
  logic [LEN_BITS-1:0] flen_r, flen_nxt;

  logic                consume;
  logic                stop, gap, take_byte;
  logic [1:0]          n;
  result_t             res [2];

  assign consume  = a_v_r & room;
  assign in_ready = ~a_v_r | consume;

  function automatic phase_t after_pic(logic from_tl0, logic [7:0] fl);
    if (!from_tl0 && fl[FL_L_BIT]) return PH_TL0;
    if (fl[FL_T_BIT] || fl[FL_K_BIT]) return PH_TK;
    return PH_JUDGE;
  endfunction

  always_comb begin
    ph_nxt    = ph_r;
    fl_nxt    = fl_r;
    hdr_nxt   = hdr_r;
    fo_nxt    = fo_r;
    pa_nxt    = pa_r;
    fk_nxt    = fk_r;
    fp_nxt    = fp_r;
    lseq_nxt  = lseq_r;
    flen_nxt  = flen_r;
    stop      = 1'b0;
    gap       = 1'b0;
    take_byte = 1'b0;
    n         = 2'd0;
    res[0]    = '0;
    res[1]    = '0;
    if (a_v_r) begin
      if (a_first_r) begin
        fl_nxt  = {3'b000, a_byte_r[2:0], a_byte_r[4], a_byte_r[5]};
        hdr_nxt = '0;
        pa_nxt  = 1'b0;
        ph_nxt  = a_byte_r[7] ? PH_EXT : PH_JUDGE;
      end else begin
        unique case (ph_r)
          PH_IDLE: begin
            stop = 1'b1;
          end
          PH_EXT: begin
            if (a_byte_r[5]) fl_nxt[FL_T_BIT] = 1'b1;
            if (a_byte_r[4]) fl_nxt[FL_K_BIT] = 1'b1;
            if (a_byte_r[6]) fl_nxt[FL_L_BIT] = 1'b1;
            ph_nxt = a_byte_r[7] ? PH_PIC : after_pic(1'b0, fl_nxt);
          end
          PH_PIC: begin
            if (a_byte_r[7]) begin
              hdr_nxt.picture_id = {a_byte_r[6:0], 8'h00};
              ph_nxt = PH_PIC2;
            end else begin
              hdr_nxt.picture_id = {8'h00, a_byte_r[6:0]};
              ph_nxt = after_pic(1'b0, fl_nxt);
            end
          end
          PH_PIC2: begin
            hdr_nxt.picture_id[7:0] = hdr_r.picture_id[7:0] | a_byte_r;
            ph_nxt = after_pic(1'b0, fl_nxt);
          end
          PH_TL0: begin
            hdr_nxt.tl0_index = a_byte_r;
            ph_nxt = after_pic(1'b1, fl_nxt);
          end
          PH_TK: begin
            hdr_nxt.temporal_id = a_byte_r[7:6];
            hdr_nxt.layer_sync  = a_byte_r[5];
            hdr_nxt.key_index   = a_byte_r[4:0];
            ph_nxt = PH_JUDGE;
          end
          PH_JUDGE: begin
            // The first payload byte judges the packet and carries the key bit.
            ph_nxt = PH_PAYLOAD;
            if (fl_nxt[FL_S_BIT] && fl_nxt[4:2] == 3'd0) begin
              fo_nxt   = 1'b1;
              flen_nxt = '0;
              fp_nxt   = 1'b1;
              fk_nxt   = ~a_byte_r[0];
              pa_nxt   = 1'b1;
              lseq_nxt = a_seq_r;
            end else if (!fo_nxt) begin
              pa_nxt = 1'b0;
            end else if (16'(a_seq_r - lseq_nxt) != 16'd1) begin
              pa_nxt = 1'b0;
              gap    = 1'b1;
            end else begin
              pa_nxt   = 1'b1;
              lseq_nxt = a_seq_r;
            end
            if (gap) begin
              fo_nxt   = 1'b0;
              flen_nxt = '0;
              fk_nxt   = 1'b0;
              fp_nxt   = 1'b0;
              res[n[0]] = mk_res(KIND_ABORT, 8'h00, 1'b0, fk_nxt, fl_nxt, hdr_nxt);
              n = n + 2'd1;
              ph_nxt = a_last_r ? PH_IDLE : PH_PAYLOAD;
              stop = 1'b1;
            end else begin
              take_byte = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            take_byte = 1'b1;
          end
        endcase
        if (take_byte && pa_nxt) begin
          if (flen_nxt != {LEN_BITS{1'b1}}) flen_nxt = flen_nxt + LEN_BITS'(1);
          res[n[0]] = mk_res(KIND_BYTE, a_byte_r, fp_nxt, fk_nxt, fl_nxt, hdr_nxt);
          n = n + 2'd1;
          fp_nxt = 1'b0;
        end
      end

      if (!stop && a_last_r) begin
        if (ph_nxt == PH_EXT || ph_nxt == PH_PIC || ph_nxt == PH_PIC2 ||
            ph_nxt == PH_TL0 || ph_nxt == PH_TK) begin
          res[n[0]] = mk_res(KIND_TRUNCATED, 8'h00, 1'b0, fk_nxt, fl_nxt, hdr_nxt);
          n = n + 2'd1;
        end else begin
          // A packet without payload bytes is judged here as a non-key packet.
          if (ph_nxt == PH_JUDGE) begin
            if (fl_nxt[FL_S_BIT] && fl_nxt[4:2] == 3'd0) begin
              fo_nxt   = 1'b1;
              flen_nxt = '0;
              fp_nxt   = 1'b1;
              fk_nxt   = 1'b0;
              pa_nxt   = 1'b1;
              lseq_nxt = a_seq_r;
            end else if (!fo_nxt) begin
              pa_nxt = 1'b0;
            end else if (16'(a_seq_r - lseq_nxt) != 16'd1) begin
              pa_nxt = 1'b0;
              gap    = 1'b1;
            end else begin
              pa_nxt   = 1'b1;
              lseq_nxt = a_seq_r;
            end
          end
          if (gap) begin
            fo_nxt   = 1'b0;
            flen_nxt = '0;
            fk_nxt   = 1'b0;
            fp_nxt   = 1'b0;
            res[n[0]] = mk_res(KIND_ABORT, 8'h00, 1'b0, fk_nxt, fl_nxt, hdr_nxt);
            n = n + 2'd1;
          end else if (pa_nxt) begin
            if (a_mark_r) begin
              res[n[0]] = mk_res(KIND_COMPLETE, 8'h00, 1'b0, fk_nxt, fl_nxt, hdr_nxt);
              n = n + 2'd1;
              fo_nxt   = 1'b0;
              flen_nxt = '0;
              fk_nxt   = 1'b0;
              fp_nxt   = 1'b0;
            end else if (CMP_W'(flen_nxt) > CMP_W'(max_frame_bytes)) begin
              res[n[0]] = mk_res(KIND_TOO_LARGE, 8'h00, 1'b0, fk_nxt, fl_nxt, hdr_nxt);
              n = n + 2'd1;
              fo_nxt   = 1'b0;
              flen_nxt = '0;
              fk_nxt   = 1'b0;
              fp_nxt   = 1'b0;
            end
          end
        end
        ph_nxt = PH_IDLE;
        pa_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    push.v0 = consume & (n != 2'd0);
    push.v1 = consume & (n == 2'd2);
    push.d0 = res[0];
    push.d1 = res[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_v_r <= 1'b1;
    end else if (consume) begin
      a_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_byte_r  <= in_byte;
      a_first_r <= in_first;
      a_last_r  <= in_last;
      a_mark_r  <= in_marker;
      a_seq_r   <= in_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      fl_r   <= '0;
      hdr_r  <= '0;
      fo_r   <= 1'b0;
      pa_r   <= 1'b0;
      fk_r   <= 1'b0;
      fp_r   <= 1'b0;
      lseq_r <= '0;
      flen_r <= '0;
    end else if (consume) begin
      ph_r   <= ph_nxt;
      fl_r   <= fl_nxt;
      hdr_r  <= hdr_nxt;
      fo_r   <= fo_nxt;
      pa_r   <= pa_nxt;
      fk_r   <= fk_nxt;
      fp_r   <= fp_nxt;
      lseq_r <= lseq_nxt;
      flen_r <= flen_nxt;
    end
  end

  // With no frame open, all frame bookkeeping is back at its cleared values.
  `ASSERT_CHK(a_closed_clean, !fo_r |-> (flen_r == '0 && !fk_r && !fp_r))
  // Bytes are only accepted into an open frame.
  `ASSERT_CHK(a_acc_needs_open, pa_r |-> fo_r)
  // Between packets no packet is marked as accepted.
  `ASSERT_CHK(a_idle_not_acc, (ph_r == PH_IDLE) |-> !pa_r)

endmodule
`default_nettype wire

[src/vp8d_out_fifo.sv]
// Small result queue that takes up to two results per cycle and delivers one.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vp8d_out_fifo import vp8d_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire res_push_t push,
  output logic           room,
  output logic           out_valid,
  input  wire logic      out_ready,
  output result_t        out_data
);

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  result_t           mem [OUT_DEPTH];
  logic [PTR_W-1:0]  wr_r, rd_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pop;
  logic [1:0]        n_push;

  assign pop       = out_valid & out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_r];
  // Room for two results regardless of whether the head leaves this cycle.
  assign room      = (cnt_r <= CNT_W'(OUT_DEPTH - 2));
  assign n_push    = {1'b0, push.v0} + {1'b0, push.v1};
  assign cnt_nxt   = cnt_r + CNT_W'(n_push) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PTR_W'(n_push);
      rd_r  <= rd_r + PTR_W'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) mem[wr_r] <= push.d0;
    if (push.v1) mem[wr_r + PTR_W'(1)] <= push.d1;
  end

  `ASSERT_CHK(a_cnt_bound, cnt_r <= CNT_W'(OUT_DEPTH))
  `ASSERT_CHK(a_push_order, push.v1 |-> push.v0)
  `ASSERT_CHK(a_push_room, push.v0 |-> room)

endmodule
`default_nettype wire

[src/vp8_rtp_depacketizer_top.sv]
// Results of an item pass the input register and then the result queue before output.
// Throughput: one item per cycle while the queue has room; an item with two results
// holds the second in the four-entry queue; output of one result per cycle bounds it.
// The input register is freed only when the queue has room for two results.
// Reset (rst_n low, synchronous) empties the queue, clears parse and frame state
// and loads max_frame_bytes with 524288.
`timescale 1ns / 1ps
`default_nettype none
module vp8_rtp_depacketizer_top import vp8d_pkg::*; #(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // payload_byte [7:0], rtp_sequence [23:8]
  input  wire logic [23:0]      in_tdata,
  // packet_first [0], rtp_marker [1]
  input  wire logic [1:0]       in_tuser,
  input  wire logic             in_tlast,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // frame_byte [7:0], frame_first [8], keyframe [9], non_reference [10],
  // partition_id [13:11], picture_id [28:14], tl0_index [36:29],
  // temporal_id [38:37], layer_sync [39], key_index [44:40], zero [47:45]
  output logic [47:0]           out_tdata,
  // result_kind [2:0]
  output logic [2:0]            out_tuser,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] max_r;
  res_push_t        push;
  logic             room;
  result_t          head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_FRAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_r <= cfg_data;
    end
  end

  vp8d_parser #(.LEN_BITS(LEN_BITS)) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_byte         (in_tdata[7:0]),
    .in_first        (in_tuser[0]),
    .in_last         (in_tlast),
    .in_marker       (in_tuser[1]),
    .in_seq          (in_tdata[23:8]),
    .max_frame_bytes (max_r),
    .room            (room),
    .push            (push)
  );

  vp8d_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (head)
  );

  assign out_tuser = head.kind;
  assign out_tdata = {3'b000, head.key_index, head.layer_sync, head.temporal_id,
                      head.tl0_index, head.picture_id, head.partition_id,
                      head.non_reference, head.keyframe, head.frame_first,
                      head.frame_byte};

endmodule
`default_nettype wire
